[rtl/pidl_pkg.sv]
// Shared types, codes and sizes for the positional insert/delete list.
package pidl_pkg;

    // Field widths fixed by the interface
    localparam int KIND_W   = 2;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // Default number of list entries
    localparam int DEPTH_DEF = 64;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic                     ins_en;
        logic                     rem_en;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

[rtl/pidl_cell.sv]
// One storage cell of the list chain: holds a word, shifts with its neighbours.
module pidl_cell #(
    parameter int IDX = 0
) (
    input  logic                               i_clk,
    input  pidl_pkg::t_cell_cmd                i_cmd,
    input  logic signed [pidl_pkg::DATA_W-1:0] i_left,
    input  logic signed [pidl_pkg::DATA_W-1:0] i_right,
    output logic signed [pidl_pkg::DATA_W-1:0] o_word,
    output logic signed [pidl_pkg::DATA_W-1:0] o_sel_word
);
    import pidl_pkg::*;

    logic signed [DATA_W-1:0] r_word;
    logic signed [DATA_W-1:0] n_word;
    logic                     w_above;
    logic                     w_here;

    // position compare against this cell's place in the chain
    assign w_above = 32'(IDX) > 32'(i_cmd.pos);
    assign w_here  = 32'(IDX) == 32'(i_cmd.pos);

    // next word: shift up on insert, shift down on remove, else hold
    always_comb begin
        n_word = r_word;
        if (i_cmd.ins_en) begin
            if (w_above) begin
                n_word = i_left;
            end else if (w_here) begin
                n_word = i_cmd.value;
            end
        end else if (i_cmd.rem_en) begin
            if (w_above || w_here) begin
                n_word = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word     = r_word;
    // word offered to the read-out OR tree when addressed
    assign o_sel_word = w_here ? r_word : '0;

endmodule

[rtl/positional_insert_delete_list_unit.sv]
// Positional insert/delete list: a chain of word cells with count and status decode.
// Each accepted input beat's result is registered in the output register.
// Throughput: one beat per cycle while the output register drains; every cell shifts
// in the same cycle, so only the output handshake can hold the flow.
// Reset: synchronous, active low; clears the count and output valid, the cells
// hold undefined words until written and need no clearing pass.
module positional_insert_delete_list_unit #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [pidl_pkg::KIND_W-1:0]          i_kind,
    input  logic [pidl_pkg::POS_W-1:0]           i_position,
    input  logic signed [pidl_pkg::DATA_W-1:0]   i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [pidl_pkg::DATA_W-1:0]   o_data,
    output logic [pidl_pkg::COUNT_W-1:0]         o_count,
    output logic [pidl_pkg::STATUS_W-1:0]        o_status
);
    import pidl_pkg::*;

    localparam int HW = $clog2(DEPTH + 1);

    logic [HW-1:0]            r_held;
    logic [HW-1:0]            n_held;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_data;
    logic [COUNT_W-1:0]       r_count;
    logic [STATUS_W-1:0]      r_status;

    logic                     w_in_acc;
    logic                     w_full;
    logic                     w_pos_gt;
    logic                     w_pos_ge;
    logic                     w_ins_ok;
    logic                     w_rem_ok;
    logic                     w_rd_ok;
    logic [STATUS_W-1:0]      w_status;
    logic signed [DATA_W-1:0] w_rd_word;
    logic signed [DATA_W-1:0] w_data;
    t_cell_cmd                w_cmd;

    logic signed [DATA_W-1:0] w_word     [DEPTH];
    logic signed [DATA_W-1:0] w_sel_word [DEPTH];

    // handshake: output register drains while a new beat enters
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // range and fill checks
    assign w_full   = r_held == HW'(DEPTH);
    assign w_pos_gt = 32'(i_position) > 32'(r_held);
    assign w_pos_ge = 32'(i_position) >= 32'(r_held);

    always_comb begin
        w_ins_ok = 1'b0;
        w_rem_ok = 1'b0;
        w_rd_ok  = 1'b0;
        w_status = ST_RANGE;
        case (i_kind)
            KIND_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (!w_pos_gt) begin
                    w_status = ST_OK;
                    w_ins_ok = 1'b1;
                end
            end
            KIND_REMOVE: begin
                if (!w_pos_ge) begin
                    w_status = ST_OK;
                    w_rem_ok = 1'b1;
                end
            end
            KIND_READ: begin
                if (!w_pos_ge) begin
                    w_status = ST_OK;
                    w_rd_ok  = 1'b1;
                end
            end
            default: begin
                w_status = ST_RANGE;
            end
        endcase
    end

    // command broadcast to the chain
    assign w_cmd.ins_en = w_in_acc && w_ins_ok;
    assign w_cmd.rem_en = w_in_acc && w_rem_ok;
    assign w_cmd.pos    = i_position;
    assign w_cmd.value  = i_value;

    // the chain of cells, each wired to its neighbours
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_word[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_word[g];
        end else begin : g_mid_r
            assign w_right = w_word[g+1];
        end
        pidl_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_word     (w_word[g]),
            .o_sel_word (w_sel_word[g])
        );
    end

    // read-out: OR of the addressed cell's word
    always_comb begin
        w_rd_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd_word = w_rd_word | w_sel_word[k];
        end
    end

    assign w_data = (w_rem_ok || w_rd_ok) ? w_rd_word : '0;

    // count after this beat
    always_comb begin
        n_held = r_held;
        if (w_cmd.ins_en) begin
            n_held = r_held + HW'(1);
        end else if (w_cmd.rem_en) begin
            n_held = r_held - HW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_held <= n_held;
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_data   <= w_data;
            r_count  <= COUNT_W'(n_held);
            r_status <= w_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data      = r_data;
    assign o_count     = r_count;
    assign o_status    = r_status;

`ifndef ASSERT_OFF
    // count never exceeds the chain length
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_held) <= 32'(DEPTH))
        else $error("held count above depth");

    // count moves only on an accepted beat
    a_held_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> $stable(r_held))
        else $error("held count changed without a beat");

    // a good insert grows the list by exactly one
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ins_en |=> r_held == $past(r_held) + HW'(1))
        else $error("insert did not grow the list by one");

    // a full report always carries the full count
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FULL) |-> r_count == COUNT_W'(DEPTH))
        else $error("full status with wrong count");
`endif

endmodule
